/* sv/cdq_pkg.sv */
// Shared types and constants for the circular deque.
`timescale 1ns / 1ps
`default_nettype none

package cdq_pkg;

    localparam int CAPACITY = 8;
    localparam int IDXW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNTW     = $clog2(CAPACITY + 1);
    localparam int SUMW     = CNTW + 1;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_REAR  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_REAR   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_REAR  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef struct packed {
        logic [2:0]         op;
        logic signed [31:0] push_value;
    } t_in;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic [1:0]         status;
        logic [3:0]         entry_count;
        logic               is_empty;
        logic               is_full;
    } t_out;

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic exec;
        logic load_out;
    } t_cmd;

endpackage

`default_nettype wire

/* sv/cdq_ctrl.sv */
// Controller state machine for the circular deque.
`timescale 1ns / 1ps
`default_nettype none

module cdq_ctrl
    import cdq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    always_comb begin
        cmd         = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.load_in = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                cmd.exec = 1'b1;
                n_state  = S_DONE;
            end
            S_DONE: begin
                // hold until the output register is free or being drained
                if (!r_out_valid || !i_stall) begin
                    cmd.load_out = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_cmd   = cmd;

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_EXEC))
        else $error("accepted request did not enter execution");

    a_exec_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_DONE))
        else $error("execution did not reach the done state");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!r_out_valid || !i_stall))
        else $error("output register loaded while a result still waits");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |=> o_valid)
        else $error("loaded result not presented");

endmodule

`default_nettype wire

/* sv/cdq_dp.sv */
// Datapath for the circular deque: ring store, indices and result register.
`timescale 1ns / 1ps
`default_nettype none

module cdq_dp
    import cdq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_in  i_req,
    output t_out      o_rsp
);

    logic [31:0]     r_ring [CAPACITY];
    logic [2:0]      r_op;
    logic [31:0]     r_word;
    logic [IDXW-1:0] r_front, n_front;
    logic [CNTW-1:0] r_count, n_count;
    logic [31:0]     r_rdata;
    logic            r_rd_ok, n_rd_ok;
    logic [1:0]      r_status, n_status;
    t_out            r_rsp;

    logic            empty, full;
    logic [SUMW-1:0] sum, sum_m1, rear_w, rear_m1_w;
    logic [IDXW-1:0] front_m1, front_p1, rear, rear_m1;
    logic [IDXW-1:0] wr_addr, rd_addr;
    logic            wr_en, rd_front;

    assign empty = (r_count == '0);
    assign full  = (r_count == CNTW'(CAPACITY));

    // wrap arithmetic without a modulo: sums stay below twice the capacity
    assign sum       = SUMW'(r_front) + SUMW'(r_count);
    assign sum_m1    = sum - SUMW'(1);
    assign rear_w    = (sum >= SUMW'(CAPACITY)) ? sum - SUMW'(CAPACITY) : sum;
    assign rear_m1_w = (sum_m1 >= SUMW'(CAPACITY)) ? sum_m1 - SUMW'(CAPACITY) : sum_m1;
    assign rear      = rear_w[IDXW-1:0];
    assign rear_m1   = rear_m1_w[IDXW-1:0];
    assign front_m1  = (r_front == '0) ? IDXW'(CAPACITY - 1) : r_front - IDXW'(1);
    assign front_p1  = (r_front == IDXW'(CAPACITY - 1)) ? '0 : r_front + IDXW'(1);

    assign rd_front = r_op inside {OP_POP_FRONT, OP_PEEK_FRONT};
    assign rd_addr  = rd_front ? r_front : rear_m1;

    always_comb begin
        n_front  = r_front;
        n_count  = r_count;
        n_status = ST_OK;
        n_rd_ok  = 1'b0;
        wr_en    = 1'b0;
        wr_addr  = rear;
        case (r_op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    wr_addr = front_m1;
                    n_front = front_m1;
                    n_count = r_count + CNTW'(1);
                end
            end
            OP_PUSH_REAR: begin
                if (full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    wr_en   = 1'b1;
                    n_count = r_count + CNTW'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_rd_ok = 1'b1;
                    n_front = front_p1;
                    n_count = r_count - CNTW'(1);
                end
            end
            OP_POP_REAR: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_rd_ok = 1'b1;
                    n_count = r_count - CNTW'(1);
                end
            end
            OP_PEEK_FRONT, OP_PEEK_REAR: begin
                if (empty) begin
                    n_status = ST_UNDERFLOW;
                end else begin
                    n_rd_ok = 1'b1;
                end
            end
            default: begin
                // unused codes leave everything alone
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && wr_en) begin
            r_ring[wr_addr] <= r_word;
        end
        if (i_cmd.exec) begin
            r_rdata <= r_ring[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_op   <= i_req.op;
            r_word <= i_req.push_value;
        end
        if (i_cmd.exec) begin
            r_rd_ok  <= n_rd_ok;
            r_status <= n_status;
        end
        if (i_cmd.load_out) begin
            r_rsp.read_value  <= r_rd_ok ? r_rdata : '0;
            r_rsp.status      <= r_status;
            r_rsp.entry_count <= 4'(r_count);
            r_rsp.is_empty    <= (r_count == '0);
            r_rsp.is_full     <= (r_count >= CNTW'(CAPACITY));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    assign o_rsp = r_rsp;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAPACITY))
        else $error("stored count above capacity");

    a_front_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_front < IDXW'(CAPACITY - 1) || r_front == IDXW'(CAPACITY - 1))
        else $error("front index outside the ring");

    a_overflow_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && n_status == ST_OVERFLOW) |=> $stable(r_count) && $stable(r_front))
        else $error("rejected push changed the ring state");

endmodule

`default_nettype wire

/* sv/circular_deque.sv */
// Top level of the circular deque: controller and datapath.
//
//  channel   direction  valid     stall     payload
//  request   in         i_valid   o_stall   i_req  (t_in)
//  response  out        o_valid   i_stall   o_rsp  (t_out)
//
// Each request passes through capture, ring access with a registered read,
// and load of the response register.
// A waiting response does not block the next request; only the load of the
// following response waits while i_stall holds the output register.
// Synchronous active-low reset clears the indices and handshake state;
// ring contents are not cleared and are only read once written.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque
    import cdq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    input  wire t_in  i_req,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_out      o_rsp
);

    t_cmd cmd;

    cdq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (cmd)
    );

    cdq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench for the circular deque: directed table, random traffic, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import cdq_pkg::*;

    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;
    localparam int ITEM_TARGET   = 1250;
    localparam int IDLE_LIMIT    = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int MAX_PRINTED   = 40;

    typedef struct packed {
        t_in  req;
        logic typed;
        t_out rsp;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_valid;
    logic o_stall;
    t_in  i_req;
    logic o_valid;
    logic i_stall;
    t_out o_rsp;

    // Shadow copy of the deque
    logic [31:0] shadow_ring [CAPACITY];
    int          shadow_front;
    int          shadow_count;

    t_out expected_rsp [$];
    t_row directed_rows [$];
    t_out rsp_want;
    int   mismatch_count;
    int   idle_cycles;
    int   send_count;
    bit   send_calm;

    circular_deque i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_rsp   (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one request to the shadow deque and return the response it should give.
    function automatic t_out apply_request(input t_in req);
        t_out r;
        int   slot;
        bit   at_front;
        r        = '0;
        r.status = ST_OK;
        at_front = (req.op == OP_POP_FRONT) || (req.op == OP_PEEK_FRONT);
        case (req.op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (shadow_count >= CAPACITY) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    if (req.op == OP_PUSH_FRONT) begin
                        shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
                        slot = shadow_front;
                    end else begin
                        slot = (shadow_front + shadow_count) % CAPACITY;
                    end
                    shadow_ring[slot] = req.push_value;
                    shadow_count++;
                end
            end
            OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT, OP_PEEK_REAR: begin
                if (shadow_count == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    slot = at_front ? shadow_front
                                    : (shadow_front + shadow_count - 1) % CAPACITY;
                    r.read_value = shadow_ring[slot];
                    if (req.op == OP_POP_FRONT)
                        shadow_front = (shadow_front + 1) % CAPACITY;
                    if (req.op == OP_POP_FRONT || req.op == OP_POP_REAR)
                        shadow_count--;
                end
            end
            default: begin
            end
        endcase
        r.entry_count = shadow_count[3:0];
        r.is_empty    = (shadow_count == 0);
        r.is_full     = (shadow_count >= CAPACITY);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic add_row(input logic [2:0] op, input logic [31:0] value, input logic typed,
                           input logic [31:0] rv, input t_status st, input logic [3:0] cnt,
                           input logic emp, input logic ful);
        t_row row;
        row.req.op           = op;
        row.req.push_value   = value;
        row.typed            = typed;
        row.rsp.read_value   = rv;
        row.rsp.status       = st;
        row.rsp.entry_count  = cnt;
        row.rsp.is_empty     = emp;
        row.rsp.is_full      = ful;
        directed_rows.push_back(row);
    endtask

    // Starts and ends at a falling edge; valid stays high when the next gap is zero.
    task automatic send_request(input t_in req, input logic typed, input t_out typed_rsp);
        int   gap;
        t_out predicted;
        if (send_count % 40 == 0)
            send_calm = ($urandom_range(0, 3) == 0);
        send_count++;
        gap = send_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= req;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_request(req);
        expected_rsp.push_back(typed ? typed_rsp : predicted);
        @(negedge i_clk);
    endtask

    // Request side
    initial begin
        t_row        row;
        t_in         req;
        int          counted;
        int          bias;
        int          push_pct;
        int          pick;
        bit          paused;
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_req          = '0;
        shadow_front   = 0;
        shadow_count   = 0;
        mismatch_count = 0;
        send_count     = 0;
        send_calm      = 1'b0;

        add_row(OP_POP_FRONT,  32'h1234_5678, 1'b1, 32'h0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0);
        add_row(OP_POP_REAR,   32'hFFFF_FFFF, 1'b1, 32'h0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0);
        add_row(OP_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'h0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0);
        add_row(OP_PEEK_REAR,  32'h8000_0000, 1'b1, 32'h0, ST_UNDERFLOW, 4'd0, 1'b1, 1'b0);
        add_row(OP_SPARE_6,    32'h7FFF_FFFF, 1'b1, 32'h0, ST_OK,        4'd0, 1'b1, 1'b0);
        add_row(OP_SPARE_7,    32'hFFFF_FFFF, 1'b1, 32'h0, ST_OK,        4'd0, 1'b1, 1'b0);
        add_row(OP_PUSH_REAR,  32'h7FFF_FFFF, 1'b1, 32'h0, ST_OK,        4'd1, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0, ST_OK,        4'd2, 1'b0, 1'b0);
        add_row(OP_PEEK_FRONT, 32'h0000_0000, 1'b1, 32'h8000_0000, ST_OK, 4'd2, 1'b0, 1'b0);
        add_row(OP_PEEK_REAR,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_OK, 4'd2, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'hFFFF_FFFF, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'h0000_0001, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'h55AA_55AA, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_FRONT, 32'hAA55_AA55, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PUSH_REAR,  32'h1234_5678, 1'b1, 32'h0, ST_OK,        4'd8, 1'b0, 1'b1);
        add_row(OP_PUSH_REAR,  32'hFFFF_FFFF, 1'b1, 32'h0, ST_OVERFLOW,  4'd8, 1'b0, 1'b1);
        add_row(OP_PUSH_FRONT, 32'h8000_0000, 1'b1, 32'h0, ST_OVERFLOW,  4'd8, 1'b0, 1'b1);
        add_row(OP_SPARE_7,    32'h0000_0000, 1'b1, 32'h0, ST_OK,        4'd8, 1'b0, 1'b1);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PEEK_FRONT, 32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_PEEK_REAR,  32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_POP_REAR,   32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);
        add_row(OP_POP_FRONT,  32'h0000_0000, 1'b0, 32'h0, ST_OK, 4'd0, 1'b0, 1'b0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_request(row.req, row.typed, row.rsp);
        end

        counted = 0;
        bias    = 2;
        paused  = 1'b0;
        while (counted < ITEM_TARGET) begin
            // Swing between filling, draining and balanced traffic to hit both ends often
            if (send_count % 24 == 0)
                bias = $urandom_range(0, 2);
            push_pct = (bias == 0) ? 65 : (bias == 1) ? 30 : 48;
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                req.op = $urandom_range(0, 1) ? OP_SPARE_7 : OP_SPARE_6;
            end else if (pick < 3 + push_pct) begin
                req.op = $urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT;
            end else begin
                case ($urandom_range(0, 5))
                    0, 1:    req.op = OP_POP_FRONT;
                    2, 3:    req.op = OP_POP_REAR;
                    4:       req.op = OP_PEEK_FRONT;
                    default: req.op = OP_PEEK_REAR;
                endcase
            end
            case ($urandom_range(0, 7))
                0:       req.push_value = 32'h8000_0000;
                1:       req.push_value = 32'h7FFF_FFFF;
                2:       req.push_value = 32'h0000_0000;
                3:       req.push_value = 32'hFFFF_FFFF;
                default: req.push_value = $urandom;
            endcase
            send_request(req, 1'b0, '0);
            if (req.op != OP_SPARE_6 && req.op != OP_SPARE_7)
                counted++;

            // Hold off once until the response side has fully caught up
            if (!paused && counted == ITEM_TARGET / 2) begin
                paused = 1'b1;
                i_valid <= 1'b0;
                @(negedge i_clk);
                while (expected_rsp.size() != 0) @(negedge i_clk);
            end
        end

        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_rsp.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_rsp.size() != 0)
            report_mismatch("responses missing", expected_rsp.size(), 32'h0);
        if (mismatch_count == 0) begin
            $display("PASS circular_deque");
        end else begin
            $display("FAIL circular_deque");
        end
        $finish;
    end

    // Response side: stall for a drawn number of cycles before each response
    initial begin
        int wait_cycles;
        int served;
        bit calm;
        i_stall = 1'b0;
        served  = 0;
        calm    = 1'b0;
        do @(negedge i_clk); while (!i_rst_n);
        forever begin
            if (served % 32 == 0)
                calm = ($urandom_range(0, 3) == 0);
            wait_cycles = calm ? 0 : $urandom_range(0, 8);
            if (wait_cycles > 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
            served++;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rsp.size() == 0) begin
                report_mismatch("response without request", o_rsp.read_value, 32'h0);
            end else begin
                rsp_want = expected_rsp.pop_front();
                if (o_rsp.read_value !== rsp_want.read_value)
                    report_mismatch("read_value", o_rsp.read_value, rsp_want.read_value);
                if (o_rsp.status !== rsp_want.status)
                    report_mismatch("status", 32'(o_rsp.status), 32'(rsp_want.status));
                if (o_rsp.entry_count !== rsp_want.entry_count)
                    report_mismatch("entry_count", 32'(o_rsp.entry_count),
                                    32'(rsp_want.entry_count));
                if (o_rsp.is_empty !== rsp_want.is_empty)
                    report_mismatch("is_empty", 32'(o_rsp.is_empty), 32'(rsp_want.is_empty));
                if (o_rsp.is_full !== rsp_want.is_full)
                    report_mismatch("is_full", 32'(o_rsp.is_full), 32'(rsp_want.is_full));
            end
        end
    end

    // Watchdog: give up when neither channel moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAIL circular_deque");
                $finish;
            end
        end
    end

endmodule

/* circular_deque.f */
sv/cdq_pkg.sv
sv/cdq_ctrl.sv
sv/cdq_dp.sv
sv/circular_deque.sv
tb/sv/tb_top.sv
